[sv/cdfd_pkg.sv]
// cdfd_pkg: shared types, constants and calendar helpers
// for the calendar date unit; no dependencies
package cdfd_pkg;

    localparam int YEAR_W  = 12;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 11;

    typedef logic [YEAR_W-1:0]  t_word;
    typedef logic [MONTH_W-1:0] t_month;
    typedef logic [DAY_W-1:0]   t_day;
    typedef logic [COUNT_W-1:0] t_count;
    typedef logic [1:0]         t_cfg_index;

    localparam t_cfg_index CFG_DATE_IS_SET = 2'd0;
    localparam t_cfg_index CFG_BASE_YEAR   = 2'd1;
    localparam t_cfg_index CFG_BASE_MONTH  = 2'd2;
    localparam t_cfg_index CFG_BASE_DAY    = 2'd3;

    localparam t_word  FALLBACK_YEAR = t_word'(2025);
    localparam t_month FIRST_MONTH   = t_month'(1);
    localparam t_month LAST_MONTH    = t_month'(12);
    localparam t_day   FIRST_DAY     = t_day'(1);
    localparam t_word  CYCLE_YEARS   = t_word'(400);
    localparam t_word  CYCLE_LAST    = t_word'(399);
    localparam t_word  CENTURY_1     = t_word'(100);
    localparam t_word  CENTURY_2     = t_word'(200);
    localparam t_word  CENTURY_3     = t_word'(300);
    localparam t_word  YEAR_MAX      = t_word'(4095);
    localparam t_month FEBRUARY      = t_month'(2);
    localparam t_month APRIL         = t_month'(4);
    localparam t_month JUNE          = t_month'(6);
    localparam t_month SEPTEMBER     = t_month'(9);
    localparam t_month NOVEMBER      = t_month'(11);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MOD  = 3'b010,
        ST_WALK = 3'b100
    } t_state;

    typedef struct packed {
        logic  ge;
        t_word diff;
    } t_sub_res;

    function automatic t_day month_len(input t_month m, input logic leap);
        t_day len;
        case (m)
            FEBRUARY:                            len = leap ? t_day'(29) : t_day'(28);
            APRIL, JUNE, SEPTEMBER, NOVEMBER:    len = t_day'(30);
            default:                             len = t_day'(31);
        endcase
        return len;
    endfunction

endpackage

[sv/calendar_date_from_day_count.sv]
// calendar_date_from_day_count: advances a configured base date by a day count
// depends on cdfd_pkg and cdfd_sub_unit
//
//  channel  | ports                                         | handshake
//  ---------+-----------------------------------------------+--------------------------
//  input    | i_day_count, i_day_carry                      | i_start & !o_busy
//  result   | o_out_year, o_out_month, o_out_day            | o_valid, one cycle
//  config   | i_cfg_index, i_cfg_data                       | i_cfg_we
//
// one subtractor is reused: first to reduce the base year modulo 400, then to walk
// the date one month per cycle. busy holds through both phases and the result
// strobe rises in the cycle in which busy falls; with the date not set busy stays
// low and the result comes the next cycle.
// synchronous active-low reset; the result strobe cannot be held off.
module calendar_date_from_day_count (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    output logic                   o_busy,
    input  logic [8:0]             i_day_count,
    input  logic                   i_day_carry,
    input  logic                   i_cfg_we,
    input  cdfd_pkg::t_cfg_index   i_cfg_index,
    input  cdfd_pkg::t_word        i_cfg_data,
    output logic                   o_valid,
    output cdfd_pkg::t_word        o_out_year,
    output cdfd_pkg::t_month       o_out_month,
    output cdfd_pkg::t_day         o_out_day
);
    import cdfd_pkg::*;

    t_state r_state, n_state;
    logic   r_date_is_set;
    t_word  r_base_year;
    t_month r_base_month;
    t_day   r_base_day;

    t_word  r_year, n_year;
    t_month r_month, n_month;
    t_day   r_day, n_day;
    t_count r_n, n_n;
    t_word  r_ycyc, n_ycyc;
    logic   r_valid, n_valid;
    t_word  r_oy, n_oy;
    t_month r_om, n_om;
    t_day   r_od, n_od;

    t_word    w_a, w_b;
    t_sub_res w_res;
    logic     w_leap;
    t_day     w_len;
    logic [DAY_W:0] w_steps;

    cdfd_sub_unit u_sub (
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_res)
    );

    assign w_leap = (r_ycyc == '0) ||
                    ((r_ycyc != CENTURY_1) && (r_ycyc != CENTURY_2) &&
                     (r_ycyc != CENTURY_3) && (r_year[1:0] == 2'b00));
    assign w_len  = month_len(r_month, w_leap);
    assign w_steps = (r_day >= w_len) ? (DAY_W+1)'(1)
                                      : ({1'b0, w_len} - {1'b0, r_day} + (DAY_W+1)'(1));

    always_comb begin
        case (r_state)
            ST_MOD: begin
                w_a = r_ycyc;
                w_b = CYCLE_YEARS;
            end
            default: begin
                w_a = t_word'(r_n);
                w_b = t_word'(w_steps);
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_year  = r_year;
        n_month = r_month;
        n_day   = r_day;
        n_n     = r_n;
        n_ycyc  = r_ycyc;
        n_valid = 1'b0;
        n_oy    = r_oy;
        n_om    = r_om;
        n_od    = r_od;
        case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (!r_date_is_set) begin
                        n_valid = 1'b1;
                        n_oy    = FALLBACK_YEAR;
                        n_om    = FIRST_MONTH;
                        n_od    = FIRST_DAY;
                    end else begin
                        n_year  = r_base_year;
                        n_month = r_base_month;
                        n_day   = r_base_day;
                        n_ycyc  = r_base_year;
                        n_n     = {1'b0, i_day_carry, i_day_count};
                        n_state = ST_MOD;
                    end
                end
            end
            ST_MOD: begin
                if (w_res.ge) begin
                    n_ycyc = w_res.diff;
                end else begin
                    n_state = ST_WALK;
                end
            end
            ST_WALK: begin
                if (w_res.ge) begin
                    n_n   = w_res.diff[COUNT_W-1:0];
                    n_day = FIRST_DAY;
                    if (r_month >= LAST_MONTH) begin
                        n_month = FIRST_MONTH;
                        n_year  = r_year + t_word'(1);
                        if (r_year == YEAR_MAX || r_ycyc == CYCLE_LAST) begin
                            n_ycyc = '0;
                        end else begin
                            n_ycyc = r_ycyc + t_word'(1);
                        end
                    end else begin
                        n_month = r_month + t_month'(1);
                    end
                end else begin
                    n_valid = 1'b1;
                    n_oy    = r_year;
                    n_om    = r_month;
                    n_od    = r_day + r_n[DAY_W-1:0];
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_valid       <= 1'b0;
            r_date_is_set <= 1'b0;
            r_base_year   <= FALLBACK_YEAR;
            r_base_month  <= FIRST_MONTH;
            r_base_day    <= FIRST_DAY;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DATE_IS_SET: r_date_is_set <= i_cfg_data[0];
                    CFG_BASE_YEAR:   r_base_year   <= i_cfg_data;
                    CFG_BASE_MONTH:  r_base_month  <= i_cfg_data[MONTH_W-1:0];
                    CFG_BASE_DAY:    r_base_day    <= i_cfg_data[DAY_W-1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_year  <= n_year;
        r_month <= n_month;
        r_day   <= n_day;
        r_n     <= n_n;
        r_ycyc  <= n_ycyc;
        r_oy    <= n_oy;
        r_om    <= n_om;
        r_od    <= n_od;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_out_year  = r_oy;
    assign o_out_month = r_om;
    assign o_out_day   = r_od;

endmodule

[sv/cdfd_sub_unit.sv]
// cdfd_sub_unit: shared subtract and compare unit
// depends on cdfd_pkg
module cdfd_sub_unit (
    input  cdfd_pkg::t_word    i_a,
    input  cdfd_pkg::t_word    i_b,
    output cdfd_pkg::t_sub_res o_res
);
    import cdfd_pkg::*;

    logic [YEAR_W:0] w_diff;

    assign w_diff     = {1'b0, i_a} - {1'b0, i_b};
    assign o_res.ge   = ~w_diff[YEAR_W];
    assign o_res.diff = w_diff[YEAR_W-1:0];

endmodule
